// ===== hdl/keyed_record_table_macros.svh =====
// keyed_record_table_macros.svh: assertion macros shared by the keyed record table RTL.
// Each macro expects i_clk and i_rst_n in the scope where it is used.
`ifndef KEYED_RECORD_TABLE_MACROS_SVH
`define KEYED_RECORD_TABLE_MACROS_SVH

// Same-cycle implication, checked outside reset
`define KRT_ASSERT_IMPL(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked outside reset
`define KRT_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hdl/krt_pkg.sv =====
// krt_pkg: request and status codes, record layout and the controller/datapath
// command and status bundles of the keyed record table. No dependencies.
`timescale 1ns / 1ps

package krt_pkg;

    // Request kinds (input tuser)
    localparam logic [1:0] REQ_INSERT = 2'd0;
    localparam logic [1:0] REQ_DELETE = 2'd1;
    localparam logic [1:0] REQ_LOOKUP = 2'd2;

    // Result status (output tuser)
    localparam logic [1:0] STS_DONE     = 2'd0;
    localparam logic [1:0] STS_DUP      = 2'd1;
    localparam logic [1:0] STS_NOTFOUND = 2'd2;
    localparam logic [1:0] STS_FULL     = 2'd3;

    // Output word: count(5) index(4) four data words, padded to 144 bits
    localparam int OUT_TDATA_W = 144;
    localparam int OUT_PAD_W   = OUT_TDATA_W - 5 - 4 - 128;

    // One stored record, key in the low bits
    typedef struct packed {
        logic [31:0] word3;
        logic [31:0] word2;
        logic [31:0] word1;
        logic [31:0] word0;
        logic [31:0] rec_key;
    } t_rec;

    localparam int REC_W = $bits(t_rec);

    // Controller to datapath
    typedef struct packed {
        logic       load_req;   // latch the incoming word, restart the scan
        logic       idx_inc;    // step the scan/shift pointer
        logic       rd_next;    // read the entry after the pointer
        logic       wr_ins;     // append the request record
        logic       wr_shift;   // move entry idx+1 down to idx
        logic       cnt_dec;    // drop the count after a delete
        logic       take_idx;   // report the pointer as the found position
        logic       take_words; // capture the read data words
        logic       set_st;     // overwrite the status
        logic [1:0] st_code;
        logic       out_load;   // move the result into the output register
    } t_cmd;

    // Datapath to controller
    typedef struct packed {
        logic is_ins;
        logic is_del;
        logic is_lkp;
        logic scan_end;   // pointer reached the count
        logic match;      // read key equals the request key
        logic full;
        logic shift_end;  // pointer is on the last stored entry
        logic out_free;
    } t_stat;

endpackage

// ===== hdl/krt_ram.sv =====
// krt_ram: generic single-write, single-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps

module krt_ram #(
    parameter int WIDTH = 160,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port and registered read port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== hdl/krt_ctrl.sv =====
// krt_ctrl: request sequencer of the keyed record table (scan, insert, shift-down).
// Depends on krt_pkg and keyed_record_table_macros.svh.
`timescale 1ns / 1ps
`include "keyed_record_table_macros.svh"

module krt_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_s_tvalid,
    output logic          o_s_tready,
    input  krt_pkg::t_stat i_st,
    output krt_pkg::t_cmd  o_cmd
);

    import krt_pkg::*;

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_SRD  = 3'd1;
    localparam logic [2:0] S_SCMP = 3'd2;
    localparam logic [2:0] S_INS  = 3'd3;
    localparam logic [2:0] S_DRD  = 3'd4;
    localparam logic [2:0] S_DWR  = 3'd5;
    localparam logic [2:0] S_DONE = 3'd6;

    logic [2:0] r_state;
    logic [2:0] n_state;
    t_cmd       w_cmd;
    logic       w_valid_req;

    assign w_valid_req = i_st.is_ins || i_st.is_del || i_st.is_lkp;
    assign o_s_tready  = (r_state == S_IDLE);

    // Next state and commands
    always_comb begin
        n_state = r_state;
        w_cmd   = '0;
        case (r_state)
            S_IDLE: begin
                if (i_s_tvalid) begin
                    w_cmd.load_req = 1'b1;
                    n_state        = S_SRD;
                end
            end
            S_SRD: begin
                if (!w_valid_req) begin
                    n_state = S_DONE;
                end else if (i_st.scan_end) begin
                    // key absent
                    if (i_st.is_ins && !i_st.full) begin
                        n_state = S_INS;
                    end else begin
                        w_cmd.set_st  = 1'b1;
                        w_cmd.st_code = i_st.is_ins ? STS_FULL : STS_NOTFOUND;
                        n_state       = S_DONE;
                    end
                end else begin
                    n_state = S_SCMP;
                end
            end
            S_SCMP: begin
                if (i_st.match) begin
                    w_cmd.take_idx = 1'b1;
                    if (i_st.is_ins) begin
                        w_cmd.set_st  = 1'b1;
                        w_cmd.st_code = STS_DUP;
                        n_state       = S_DONE;
                    end else if (i_st.is_lkp) begin
                        w_cmd.take_words = 1'b1;
                        n_state          = S_DONE;
                    end else begin
                        n_state = S_DRD;
                    end
                end else begin
                    w_cmd.idx_inc = 1'b1;
                    n_state       = S_SRD;
                end
            end
            S_INS: begin
                w_cmd.wr_ins = 1'b1;
                n_state      = S_DONE;
            end
            S_DRD: begin
                w_cmd.rd_next = 1'b1;
                if (i_st.shift_end) begin
                    w_cmd.cnt_dec = 1'b1;
                    n_state       = S_DONE;
                end else begin
                    n_state = S_DWR;
                end
            end
            S_DWR: begin
                w_cmd.wr_shift = 1'b1;
                w_cmd.idx_inc  = 1'b1;
                n_state        = S_DRD;
            end
            S_DONE: begin
                if (i_st.out_free) begin
                    w_cmd.out_load = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // State register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_cmd = w_cmd;

    `KRT_ASSERT_NEXT(a_accept_starts_scan, i_s_tvalid && o_s_tready, r_state == S_SRD, "accepted word did not start a scan")

endmodule

// ===== hdl/krt_dp.sv =====
// krt_dp: record RAM, count, scan pointer and result registers of the keyed record table.
// Depends on krt_pkg, krt_ram and keyed_record_table_macros.svh.
`timescale 1ns / 1ps
`include "keyed_record_table_macros.svh"

module krt_dp #(
    parameter int TABLE_DEPTH = 16
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  krt_pkg::t_rec                     i_s_rec,
    input  logic [1:0]                        i_s_tuser,
    input  krt_pkg::t_cmd                     i_cmd,
    output krt_pkg::t_stat                    o_st,
    output logic                              o_m_tvalid,
    input  logic                              i_m_tready,
    output logic [1:0]                        o_m_tuser,
    output logic [krt_pkg::OUT_TDATA_W-1:0]   o_m_tdata
);

    import krt_pkg::*;

    localparam int IW = $clog2(TABLE_DEPTH);
    localparam int CW = $clog2(TABLE_DEPTH + 1);

    // Control state
    logic [CW-1:0] r_idx;
    logic [CW-1:0] r_count;
    logic          r_m_valid;

    // Request and result payload
    t_rec          r_rec;
    logic [1:0]    r_req;
    logic [1:0]    r_status;
    logic [IW-1:0] r_found;
    logic [127:0]  r_words;
    logic [1:0]    r_m_user;
    logic [OUT_TDATA_W-1:0] r_m_data;

    logic [CW-1:0] w_idx_p1;
    logic [IW-1:0] w_raddr;
    logic [IW-1:0] w_waddr;
    t_rec          w_wdata;
    t_rec          w_rdata;
    logic          w_we;
    logic [31:0]   w_found_ext;
    logic [31:0]   w_count_ext;
    t_stat         w_st;

    assign w_idx_p1 = r_idx + CW'(1);

    // RAM addressing: scan reads the pointer, shift reads one past it
    assign w_raddr = i_cmd.rd_next ? w_idx_p1[IW-1:0] : r_idx[IW-1:0];
    assign w_waddr = i_cmd.wr_ins ? r_count[IW-1:0] : r_idx[IW-1:0];
    assign w_wdata = i_cmd.wr_ins ? r_rec : w_rdata;
    assign w_we    = i_cmd.wr_ins || i_cmd.wr_shift;

    krt_ram #(
        .WIDTH (REC_W),
        .DEPTH (TABLE_DEPTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    // Status back to the controller
    always_comb begin
        w_st.is_ins    = (r_req == REQ_INSERT);
        w_st.is_del    = (r_req == REQ_DELETE);
        w_st.is_lkp    = (r_req == REQ_LOOKUP);
        w_st.scan_end  = (r_idx == r_count);
        w_st.match     = (w_rdata.rec_key == r_rec.rec_key);
        w_st.full      = (r_count == CW'(TABLE_DEPTH));
        w_st.shift_end = (w_idx_p1 >= r_count);
        w_st.out_free  = !r_m_valid || i_m_tready;
    end

    assign o_st = w_st;

    // Pointer, count and output valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx     <= '0;
            r_count   <= '0;
            r_m_valid <= 1'b0;
        end else begin
            if (i_cmd.load_req) begin
                r_idx <= '0;
            end else if (i_cmd.idx_inc) begin
                r_idx <= w_idx_p1;
            end
            if (i_cmd.wr_ins) begin
                r_count <= r_count + CW'(1);
            end else if (i_cmd.cnt_dec) begin
                r_count <= r_count - CW'(1);
            end
            if (i_cmd.out_load) begin
                r_m_valid <= 1'b1;
            end else if (i_m_tready) begin
                r_m_valid <= 1'b0;
            end
        end
    end

    // Indexes widened, then cut to the result field widths
    assign w_found_ext = 32'(r_found);
    assign w_count_ext = 32'(r_count);

    // Request latch and result assembly
    always_ff @(posedge i_clk) begin
        if (i_cmd.load_req) begin
            r_rec    <= i_s_rec;
            r_req    <= i_s_tuser;
            r_status <= STS_DONE;
            r_found  <= '0;
            r_words  <= '0;
        end
        if (i_cmd.set_st) begin
            r_status <= i_cmd.st_code;
        end
        if (i_cmd.take_idx) begin
            r_found <= r_idx[IW-1:0];
        end else if (i_cmd.wr_ins) begin
            r_found <= r_count[IW-1:0];
        end
        if (i_cmd.take_words) begin
            r_words <= {w_rdata.word3, w_rdata.word2, w_rdata.word1, w_rdata.word0};
        end
        if (i_cmd.out_load) begin
            r_m_user <= r_status;
            r_m_data <= {{OUT_PAD_W{1'b0}}, r_words, w_found_ext[3:0], w_count_ext[4:0]};
        end
    end

    assign o_m_tvalid = r_m_valid;
    assign o_m_tuser  = r_m_user;
    assign o_m_tdata  = r_m_data;

    `KRT_ASSERT_IMPL(a_ins_has_room, i_cmd.wr_ins, r_count < CW'(TABLE_DEPTH), "append into a full table")
    `KRT_ASSERT_IMPL(a_shift_in_range, i_cmd.wr_shift, w_idx_p1 < r_count, "shift beyond the stored entries")
    `KRT_ASSERT_IMPL(a_out_not_overwritten, i_cmd.out_load, !r_m_valid || i_m_tready, "result overwritten before taken")

endmodule

// ===== hdl/keyed_record_table.sv =====
// keyed_record_table: top level, joins the request sequencer and the record datapath.
// Depends on krt_pkg, krt_ctrl, krt_dp (and krt_ram below it).
`timescale 1ns / 1ps

// A densely packed table of up to TABLE_DEPTH records (32-bit key plus four
// 32-bit data words) in one RAM with a registered read port. Requests are
// handled one at a time: the key search reads and then compares the stored
// entries in order, and a delete then moves each later entry down one place,
// reading the next entry and then writing it, starting where the search
// stopped. The result handoff waits while the output register still holds
// an untaken result. A new word is taken while the previous result still
// waits in the output register. There is no clearing pass after reset.
module keyed_record_table #(
    parameter int TABLE_DEPTH = 16
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            s_axis_tvalid,
    output logic                            s_axis_tready,
    // rec_key, in_word0, in_word1, in_word2, in_word3
    input  logic [krt_pkg::REC_W-1:0]       s_axis_tdata,
    // req_type
    input  logic [1:0]                      s_axis_tuser,
    output logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    // entry_count, found_index, out_word0, out_word1, out_word2, out_word3, zero pad
    output logic [krt_pkg::OUT_TDATA_W-1:0] m_axis_tdata,
    // status
    output logic [1:0]                      m_axis_tuser
);

    import krt_pkg::*;

    t_cmd  w_cmd;
    t_stat w_st;
    t_rec  w_rec;

    assign w_rec = s_axis_tdata;

    // Sequencer
    krt_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (s_axis_tvalid),
        .o_s_tready (s_axis_tready),
        .i_st       (w_st),
        .o_cmd      (w_cmd)
    );

    // Record storage and result path
    krt_dp #(
        .TABLE_DEPTH (TABLE_DEPTH)
    ) u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_rec    (w_rec),
        .i_s_tuser  (s_axis_tuser),
        .i_cmd      (w_cmd),
        .o_st       (w_st),
        .o_m_tvalid (m_axis_tvalid),
        .i_m_tready (m_axis_tready),
        .o_m_tuser  (m_axis_tuser),
        .o_m_tdata  (m_axis_tdata)
    );

endmodule

// ===== dv/tb_keyed_record_table.sv =====
`timescale 1ns / 1ps
// tb_keyed_record_table: self-checking bench for keyed_record_table. A scoreboard
// class keeps its own copy of the record table and checks every result word.
// Depends on krt_pkg and the keyed_record_table RTL.

module tb_keyed_record_table;
    import krt_pkg::*;

    localparam int         SLOTS        = 16;
    localparam logic [1:0] REQ_UNUSED   = 2'd3;   // request code with no action
    localparam int         HOLD_CYCLES  = 300;    // long output back-pressure
    localparam int         DRAIN_CYCLES = 80;     // > worst request latency
    localparam int         STALL_LIMIT  = 3000;   // cycles with no handshake at all
    localparam int         MAX_REPORTS  = 10;
    localparam int         POOL_SIZE    = 24;

    // One expected or observed result, fields as carried on the output side
    typedef struct packed {
        logic [1:0]  status;
        logic [4:0]  count;
        logic [3:0]  index;
        logic [31:0] w0;
        logic [31:0] w1;
        logic [31:0] w2;
        logic [31:0] w3;
    } t_table_result;

    // Scoreboard: shadow table plus a queue of the results it predicts
    class record_table_scoreboard;
        logic [31:0]   key_mem [SLOTS];
        logic [31:0]   word_mem [SLOTS][4];
        int unsigned   fill = 0;
        t_table_result expected_q[$];
        int            errors = 0;
        int            status_seen[4] = '{0, 0, 0, 0};
        int unsigned   peak_fill = 0;
        int            requests = 0;

        // Linear search over the stored records, oldest first
        function bit find_slot(logic [31:0] key, output int slot);
            slot = 0;
            for (int k = 0; k < fill; k++) begin
                if (key_mem[k] == key) begin
                    slot = k;
                    return 1'b1;
                end
            end
            return 1'b0;
        endfunction

        // Apply one accepted request to the shadow table, queue its result
        function void note_request(logic [1:0] req, t_rec rec);
            t_table_result res;
            int            slot;
            bit            hit;
            res = '0;
            res.status = STS_DONE;
            hit = find_slot(rec.rec_key, slot);
            case (req)
                REQ_INSERT: begin
                    if (hit) begin
                        res.status = STS_DUP;
                        res.index  = slot[3:0];
                    end else if (fill >= SLOTS) begin
                        res.status = STS_FULL;
                    end else begin
                        key_mem[fill]     = rec.rec_key;
                        word_mem[fill][0] = rec.word0;
                        word_mem[fill][1] = rec.word1;
                        word_mem[fill][2] = rec.word2;
                        word_mem[fill][3] = rec.word3;
                        res.index = fill[3:0];
                        fill++;
                    end
                end
                REQ_DELETE: begin
                    if (!hit) begin
                        res.status = STS_NOTFOUND;
                    end else begin
                        res.index = slot[3:0];
                        // close the gap, later records move down one place
                        for (int d = slot; d + 1 < fill; d++) begin
                            key_mem[d]  = key_mem[d + 1];
                            word_mem[d] = word_mem[d + 1];
                        end
                        fill--;
                    end
                end
                REQ_LOOKUP: begin
                    if (!hit) begin
                        res.status = STS_NOTFOUND;
                    end else begin
                        res.index = slot[3:0];
                        res.w0    = word_mem[slot][0];
                        res.w1    = word_mem[slot][1];
                        res.w2    = word_mem[slot][2];
                        res.w3    = word_mem[slot][3];
                    end
                end
                default: ;  // unused code: no change, plain done
            endcase
            res.count = fill[4:0];
            status_seen[res.status]++;
            if (fill > peak_fill) peak_fill = fill;
            requests++;
            expected_q.push_back(res);
        endfunction

        function void report(string what, t_table_result want, t_table_result got);
            errors++;
            if (errors <= MAX_REPORTS) begin
                $display("[%0t] ERROR: %s", $time, what);
                $display("  expected status %0d count %0d index %0d words %h %h %h %h",
                         want.status, want.count, want.index,
                         want.w0, want.w1, want.w2, want.w3);
                $display("  actual   status %0d count %0d index %0d words %h %h %h %h",
                         got.status, got.count, got.index,
                         got.w0, got.w1, got.w2, got.w3);
            end
        endfunction

        // Compare one accepted result word against the oldest prediction
        function void check_result(logic [1:0] status, logic [OUT_TDATA_W-1:0] data);
            t_table_result got;
            t_table_result want;
            got.status = status;
            got.count  = data[4:0];
            got.index  = data[8:5];
            got.w0     = data[40:9];
            got.w1     = data[72:41];
            got.w2     = data[104:73];
            got.w3     = data[136:105];
            if (expected_q.size() == 0) begin
                report("result word with no request pending", '0, got);
            end else begin
                want = expected_q.pop_front();
                if (got !== want) report("result mismatch", want, got);
            end
        endfunction

        function int pending();
            return expected_q.size();
        endfunction
    endclass

    logic                   i_clk;
    logic                   i_rst_n       = 1'b0;
    logic                   s_axis_tvalid = 1'b0;
    logic                   s_axis_tready;
    logic [REC_W-1:0]       s_axis_tdata  = '0;   // rec_key, word0..word3
    logic [1:0]             s_axis_tuser  = '0;   // req_type
    logic                   m_axis_tvalid;
    logic                   m_axis_tready = 1'b0;
    logic [OUT_TDATA_W-1:0] m_axis_tdata;         // count, index, word0..word3, pad
    logic [1:0]             m_axis_tuser;         // status

    record_table_scoreboard table_sb = new();

    int          tx_idle_pct  = 16;
    int          rx_idle_pct  = 84;
    bit          hold_request = 1'b0;
    int          hold_left    = 0;
    int          quiet_cycles = 0;
    logic [31:0] key_pool [POOL_SIZE];

    keyed_record_table #(
        .TABLE_DEPTH(SLOTS)
    ) dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    // 12 ns clock
    always begin
        i_clk = 1'b0;
        #6;
        i_clk = 1'b1;
        #6;
    end

    // Result side: random stalls, or a long hold-off when one is requested
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left--;
            m_axis_tready <= 1'b0;
        end else if (hold_request) begin
            hold_request = 1'b0;
            hold_left    = HOLD_CYCLES;
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= ($urandom_range(99) >= rx_idle_pct);
        end
    end

    // Monitor: results checked before the same-edge request is noted; stall watchdog
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (m_axis_tvalid && m_axis_tready)
                table_sb.check_result(m_axis_tuser, m_axis_tdata);
            if (s_axis_tvalid && s_axis_tready)
                table_sb.note_request(s_axis_tuser, s_axis_tdata);
            if ((m_axis_tvalid && m_axis_tready) || (s_axis_tvalid && s_axis_tready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
        end
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("[%0t] ERROR: no handshake for %0d cycles", $time, STALL_LIMIT);
            $display("Test completed with failures");
            $finish;
        end
    end

    // Offer one request word: optional idle gap first, then hold until taken
    task automatic offer_request(input logic [1:0] req, input t_rec rec);
        if ($urandom_range(99) < tx_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            do @(posedge i_clk); while ($urandom_range(99) < tx_idle_pct);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= req;
        s_axis_tdata  <= rec;
        do @(posedge i_clk); while (!s_axis_tready);
    endtask

    function automatic logic [31:0] table_key(int i);
        case (i)
            0:       return 32'h8000_0000;
            1:       return 32'h7FFF_FFFF;
            2:       return 32'h0000_0000;
            3:       return 32'hFFFF_FFFF;
            default: return {i[7:0], 24'h5A_5A5A};
        endcase
    endfunction

    // Mostly random data, now and then a signed extreme
    function automatic logic [31:0] pick_word();
        if ($urandom_range(9) != 0) return $urandom;
        case ($urandom_range(3))
            0:       return 32'h8000_0000;
            1:       return 32'h7FFF_FFFF;
            2:       return 32'h0000_0000;
            default: return 32'hFFFF_FFFF;
        endcase
    endfunction

    // Probe the empty table, fill to capacity (extreme keys and words first), then hit each corner case
    task automatic directed_requests();
        t_rec rec;
        rec = '0;
        offer_request(REQ_LOOKUP, rec);              // lookup on empty table
        rec.rec_key = 32'h8000_0000;
        offer_request(REQ_DELETE, rec);              // delete on empty table
        for (int i = 0; i < SLOTS; i++) begin
            rec.rec_key = table_key(i);
            case (i)
                0:       {rec.word0, rec.word1, rec.word2, rec.word3} = {4{32'h8000_0000}};
                1:       {rec.word0, rec.word1, rec.word2, rec.word3} = {4{32'h7FFF_FFFF}};
                2:       {rec.word0, rec.word1, rec.word2, rec.word3} = '0;
                3:       {rec.word0, rec.word1, rec.word2, rec.word3} = '1;
                default: {rec.word0, rec.word1, rec.word2, rec.word3} =
                             {$urandom, $urandom, $urandom, $urandom};
            endcase
            offer_request(REQ_INSERT, rec);
        end
        rec.rec_key = 32'h1234_5678;
        offer_request(REQ_INSERT, rec);              // full table refuses
        rec.rec_key = table_key(1);
        offer_request(REQ_INSERT, rec);              // duplicate key
        rec.rec_key = table_key(SLOTS - 1);
        offer_request(REQ_LOOKUP, rec);              // hit at the last position
        rec.rec_key = table_key(0);
        offer_request(REQ_DELETE, rec);              // remove first, all shift
        rec.rec_key = table_key(7);
        offer_request(REQ_DELETE, rec);              // remove from the middle
        rec.rec_key = table_key(SLOTS - 1);
        offer_request(REQ_DELETE, rec);              // remove the last one
        rec.rec_key = 32'h1234_5678;
        offer_request(REQ_DELETE, rec);              // delete of a missing key
        rec = {$urandom, $urandom, $urandom, $urandom, $urandom};
        offer_request(REQ_UNUSED, rec);              // unused code is a no-op
        rec.rec_key = table_key(3);
        offer_request(REQ_LOOKUP, rec);              // lookup after shifting
    endtask

    // Random traffic in alternating grow and shrink bursts over a small key pool
    task automatic random_requests(input int count);
        t_rec       rec;
        logic [1:0] req;
        int         roll;
        int         ins_pct;
        int         del_pct;
        bit         growing;
        growing = 1'b1;
        for (int n = 0; n < count; n++) begin
            if (n % 40 == 39) growing = !growing;
            ins_pct = growing ? 60 : 15;
            del_pct = growing ? 10 : 55;
            roll    = $urandom_range(99);
            if (roll < 5)                          req = REQ_UNUSED;
            else if (roll < 5 + ins_pct)           req = REQ_INSERT;
            else if (roll < 5 + ins_pct + del_pct) req = REQ_DELETE;
            else                                   req = REQ_LOOKUP;
            rec.rec_key = ($urandom_range(99) < 85) ? key_pool[$urandom_range(POOL_SIZE - 1)]
                                                    : $urandom;
            rec.word0 = pick_word();
            rec.word1 = pick_word();
            rec.word2 = pick_word();
            rec.word3 = pick_word();
            offer_request(req, rec);
        end
    endtask

    // Main sequence: reset, directed part, three idling mixes, drain, verdict
    initial begin
        for (int i = 0; i < POOL_SIZE; i++)
            key_pool[i] = (i < SLOTS) ? table_key(i) : $urandom;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        tx_idle_pct = 16;
        rx_idle_pct = 84;
        directed_requests();
        random_requests(233);

        tx_idle_pct = 84;
        rx_idle_pct = 16;
        random_requests(233);

        // no idling; output held off at the start so the input backs up
        tx_idle_pct  = 0;
        rx_idle_pct  = 0;
        hold_request = 1'b1;
        random_requests(234);
        s_axis_tvalid <= 1'b0;

        while (table_sb.pending() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("Ran %0d requests: %0d done, %0d duplicate, %0d not found, %0d full",
                 table_sb.requests, table_sb.status_seen[STS_DONE],
                 table_sb.status_seen[STS_DUP], table_sb.status_seen[STS_NOTFOUND],
                 table_sb.status_seen[STS_FULL]);
        $display("Peak fill %0d of %0d records; three idling mixes and a %0d-cycle hold-off",
                 table_sb.peak_fill, SLOTS, HOLD_CYCLES);
        if (table_sb.errors == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule

// ===== keyed_record_table.f =====
+incdir+hdl
hdl/krt_pkg.sv
hdl/krt_ram.sv
hdl/krt_ctrl.sv
hdl/krt_dp.sv
hdl/keyed_record_table.sv
dv/tb_keyed_record_table.sv
